>>> src/sbpo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpo_pkg
// Types and constants of the sphere versus box push-out pipeline.
// ----------------------------------------------------------------------------
package sbpo_pkg;

  localparam int CW = 32;              // coordinate width
  localparam int HW = CW - 1;          // half extent / radius width
  localparam int AW = CW + 2;          // extended coordinate width
  localparam int EW = CW - 1;          // direction magnitude width
  localparam int SW = 2 * EW;          // square width
  localparam int LW = 32;              // length width
  localparam int PW = 32;              // push distance width
  localparam int NW = 64;              // dividend / square sum width
  localparam int MW = 16;              // margin register width
  localparam int SQ_STAGES  = NW / 2;
  localparam int DIV_STAGES = 34;
  localparam int QW = DIV_STAGES;
  localparam int I_SQ_OUT  = 4 + SQ_STAGES;
  localparam int I_DIV_IN  = I_SQ_OUT + 2;
  localparam int CTX_DEPTH = I_DIV_IN + DIV_STAGES + 1;

  typedef struct packed {
    logic signed [CW-1:0] box_center_x;
    logic signed [CW-1:0] box_center_y;
    logic signed [CW-1:0] box_center_z;
    logic [HW-1:0]        box_half_x;
    logic [HW-1:0]        box_half_y;
    logic [HW-1:0]        box_half_z;
    logic signed [CW-1:0] sphere_center_x;
    logic signed [CW-1:0] sphere_center_y;
    logic signed [CW-1:0] sphere_center_z;
    logic [HW-1:0]        sphere_radius;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] new_center_x;
    logic signed [CW-1:0] new_center_y;
    logic signed [CW-1:0] new_center_z;
  } out_t;

  typedef struct packed {
    logic                 hit;
    logic [2:0]           neg;
    logic [2:0][AW-1:0]   cl;
    logic [2:0][CW-1:0]   sc;
    logic [2:0][EW-1:0]   e;
    logic [PW-1:0]        push;
  } ctx_t;

endpackage
`default_nettype wire

>>> src/sbpo_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpo_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module sbpo_isqrt (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [sbpo_pkg::NW-1:0]  x_in,
  output logic      [sbpo_pkg::LW-1:0]  root
);

  localparam int N  = sbpo_pkg::SQ_STAGES;
  localparam int NW = sbpo_pkg::NW;

  logic [NW-1:0] x_r   [N];
  logic [NW-1:0] res_r [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    logic [NW-1:0] xi;
    logic [NW-1:0] ri;
    logic [NW-1:0] bitv;
    logic [NW-1:0] t;
    if (k == 0) begin : g_first
      assign xi = x_in;
      assign ri = '0;
    end else begin : g_next
      assign xi = x_r[k-1];
      assign ri = res_r[k-1];
    end
    assign bitv = NW'(1) << (NW - 2 - 2 * k);
    assign t    = ri + bitv;
    always_ff @(posedge clk) begin
      if (en) begin
        if (xi >= t) begin
          x_r[k]   <= xi - t;
          res_r[k] <= (ri >> 1) + bitv;
        end else begin
          x_r[k]   <= xi;
          res_r[k] <= ri >> 1;
        end
      end
    end
  end

  assign root = res_r[N-1][sbpo_pkg::LW-1:0];

endmodule
`default_nettype wire

>>> src/sbpo_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sbpo_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module sbpo_div (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic [sbpo_pkg::NW-1:0]  num_in,
  input  wire logic [sbpo_pkg::LW-1:0]  den_in,
  output logic      [sbpo_pkg::QW-1:0]  quo
);

  localparam int N  = sbpo_pkg::DIV_STAGES;
  localparam int NW = sbpo_pkg::NW;
  localparam int LW = sbpo_pkg::LW;
  localparam int QW = sbpo_pkg::QW;

  logic [LW-1:0] rem_r [N];
  logic [NW-1:0] num_r [N];
  logic [LW-1:0] den_r [N];
  logic [QW-1:0] q_r   [N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    logic [LW-1:0] ri;
    logic [NW-1:0] ni;
    logic [LW-1:0] di;
    logic [QW-1:0] qi;
    logic [LW:0]   t;
    if (k == 0) begin : g_first
      assign ri = LW'(num_in >> N);
      assign ni = num_in;
      assign di = den_in;
      assign qi = '0;
    end else begin : g_next
      assign ri = rem_r[k-1];
      assign ni = num_r[k-1];
      assign di = den_r[k-1];
      assign qi = q_r[k-1];
    end
    assign t = {ri, ni[N-1-k]};
    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= ni;
        den_r[k] <= di;
        if (t >= {1'b0, di}) begin
          rem_r[k] <= LW'(t - {1'b0, di});
          q_r[k]   <= {qi[QW-2:0], 1'b1};
        end else begin
          rem_r[k] <= t[LW-1:0];
          q_r[k]   <= {qi[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = q_r[N-1];

endmodule
`default_nettype wire

>>> src/sphere_box_push_out_top.sv
`default_nettype none
// Throughput: one transaction per cycle while no stall holds the pipeline;
// the 32-stage square root and the 34-stage dividers each take a new
// operand every cycle that the pipeline advances.
// A stall on the result side freezes the whole pipeline and raises in_stall.
// Synchronous active-low reset clears all valid bits and sets margin_r.
// ----------------------------------------------------------------------------
// sphere_box_push_out_top
// Sphere versus axis-aligned box push-out: clamp, hit test, normalize,
// square root, divide, saturate.
// ----------------------------------------------------------------------------
module sphere_box_push_out_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire sbpo_pkg::in_t    in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output sbpo_pkg::out_t        out_data,
  input  wire logic             cfg_we,
  input  wire logic [15:0]      cfg_wdata
);

  localparam int CW = sbpo_pkg::CW;
  localparam int HW = sbpo_pkg::HW;
  localparam int AW = sbpo_pkg::AW;
  localparam int EW = sbpo_pkg::EW;
  localparam int SW = sbpo_pkg::SW;
  localparam int LW = sbpo_pkg::LW;
  localparam int PW = sbpo_pkg::PW;
  localparam int NW = sbpo_pkg::NW;
  localparam int MW = sbpo_pkg::MW;
  localparam int QW = sbpo_pkg::QW;
  localparam int CD = sbpo_pkg::CTX_DEPTH;
  localparam int IS = sbpo_pkg::I_SQ_OUT;
  localparam logic [MW-1:0] MARGIN_RST = MW'(((64'd1 << FRAC_BITS) * 2 + 50) / 100);

  logic adv;
  logic [MW-1:0] margin_r;

  assign in_stall = out_valid && out_stall;
  assign adv      = !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      margin_r <= MARGIN_RST;
    end else if (cfg_we) begin
      margin_r <= cfg_wdata;
    end
  end

  logic signed [CW-1:0] c_in [3];
  logic        [HW-1:0] h_in [3];
  logic signed [CW-1:0] s_in [3];

  assign c_in[0] = in_data.box_center_x;
  assign c_in[1] = in_data.box_center_y;
  assign c_in[2] = in_data.box_center_z;
  assign h_in[0] = in_data.box_half_x;
  assign h_in[1] = in_data.box_half_y;
  assign h_in[2] = in_data.box_half_z;
  assign s_in[0] = in_data.sphere_center_x;
  assign s_in[1] = in_data.sphere_center_y;
  assign s_in[2] = in_data.sphere_center_z;

  // box bounds
  logic                 va_r;
  logic signed [AW-1:0] a_c_r  [3];
  logic signed [AW-1:0] a_s_r  [3];
  logic signed [AW-1:0] a_lo_r [3];
  logic signed [AW-1:0] a_hi_r [3];
  logic        [HW-1:0] a_rad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_rad_r <= in_data.sphere_radius;
      for (int i = 0; i < 3; i++) begin
        a_c_r[i]  <= AW'(c_in[i]);
        a_s_r[i]  <= AW'(s_in[i]);
        a_lo_r[i] <= AW'(c_in[i]) - $signed({{(AW-HW){1'b0}}, h_in[i]});
        a_hi_r[i] <= AW'(c_in[i]) + $signed({{(AW-HW){1'b0}}, h_in[i]});
      end
    end
  end

  // clamp and deltas
  logic                 vb_r;
  logic signed [AW-1:0] b_cl_r [3];
  logic signed [AW-1:0] b_d_r  [3];
  logic signed [AW-1:0] b_dc_r [3];
  logic signed [CW-1:0] b_s_r  [3];
  logic        [HW-1:0] b_rad_r;
  logic signed [AW-1:0] cl_nxt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (a_s_r[i] < a_lo_r[i]) begin
        cl_nxt[i] = a_lo_r[i];
      end else if (a_s_r[i] > a_hi_r[i]) begin
        cl_nxt[i] = a_hi_r[i];
      end else begin
        cl_nxt[i] = a_s_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (adv) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_rad_r <= a_rad_r;
      for (int i = 0; i < 3; i++) begin
        b_cl_r[i] <= cl_nxt[i];
        b_d_r[i]  <= a_s_r[i] - cl_nxt[i];
        b_dc_r[i] <= a_s_r[i] - a_c_r[i];
        b_s_r[i]  <= a_s_r[i][CW-1:0];
      end
    end
  end

  // magnitudes and flags
  logic                 vc_r;
  logic        [EW-1:0] c_ad_r   [3];
  logic        [EW-1:0] c_adc_r  [3];
  logic        [2:0]    c_negd_r;
  logic        [2:0]    c_negdc_r;
  logic                 c_far_r;
  logic                 c_dz_r;
  logic                 c_dcz_r;
  logic signed [AW-1:0] c_cl_r   [3];
  logic signed [CW-1:0] c_s_r    [3];
  logic        [HW-1:0] c_rad_r;
  logic        [PW-1:0] c_push_r;
  logic        [AW-1:0] ad_nxt   [3];
  logic        [AW-1:0] adc_nxt  [3];
  logic                 far_nxt;

  always_comb begin
    far_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ad_nxt[i]  = b_d_r[i][AW-1] ? AW'(-b_d_r[i]) : AW'(b_d_r[i]);
      adc_nxt[i] = b_dc_r[i][AW-1] ? AW'(-b_dc_r[i]) : AW'(b_dc_r[i]);
      if (ad_nxt[i] >= {{(AW-HW){1'b0}}, b_rad_r}) begin
        far_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (adv) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_far_r  <= far_nxt;
      c_dz_r   <= (b_d_r[0] == '0) && (b_d_r[1] == '0) && (b_d_r[2] == '0);
      c_dcz_r  <= (b_dc_r[0] == '0) && (b_dc_r[1] == '0) && (b_dc_r[2] == '0);
      c_rad_r  <= b_rad_r;
      c_push_r <= PW'(b_rad_r) + PW'(margin_r);
      for (int i = 0; i < 3; i++) begin
        c_ad_r[i]    <= ad_nxt[i][EW-1:0];
        c_adc_r[i]   <= adc_nxt[i][EW-1:0];
        c_negd_r[i]  <= b_d_r[i][AW-1];
        c_negdc_r[i] <= b_dc_r[i][AW-1];
        c_cl_r[i]    <= b_cl_r[i];
        c_s_r[i]     <= b_s_r[i];
      end
    end
  end

  // squares, direction select
  logic                 vd_r;
  logic        [SW-1:0] d_sq_r [3];
  logic        [SW-1:0] d_rr_r;
  logic                 d_far_r;
  logic        [EW-1:0] d_e_r  [3];
  logic        [2:0]    d_neg_r;
  logic        [EW-1:0] d_m_r;
  logic signed [AW-1:0] d_cl_r [3];
  logic signed [CW-1:0] d_s_r  [3];
  logic        [PW-1:0] d_push_r;
  logic        [EW-1:0] e_nxt  [3];
  logic        [2:0]    neg_nxt;
  logic        [EW-1:0] m_nxt;

  always_comb begin
    if (!c_dz_r) begin
      for (int i = 0; i < 3; i++) begin
        e_nxt[i] = c_ad_r[i];
      end
      neg_nxt = c_negd_r;
    end else if (!c_dcz_r) begin
      for (int i = 0; i < 3; i++) begin
        e_nxt[i] = c_adc_r[i];
      end
      neg_nxt = c_negdc_r;
    end else begin
      e_nxt[0] = EW'(1);
      e_nxt[1] = '0;
      e_nxt[2] = '0;
      neg_nxt  = '0;
    end
    m_nxt = e_nxt[0];
    if (e_nxt[1] > m_nxt) begin
      m_nxt = e_nxt[1];
    end
    if (e_nxt[2] > m_nxt) begin
      m_nxt = e_nxt[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (adv) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_rr_r   <= SW'(c_rad_r) * SW'(c_rad_r);
      d_far_r  <= c_far_r;
      d_neg_r  <= neg_nxt;
      d_m_r    <= m_nxt;
      d_push_r <= c_push_r;
      for (int i = 0; i < 3; i++) begin
        d_sq_r[i] <= SW'(c_ad_r[i]) * SW'(c_ad_r[i]);
        d_e_r[i]  <= e_nxt[i];
        d_cl_r[i] <= c_cl_r[i];
        d_s_r[i]  <= c_s_r[i];
      end
    end
  end

  // hit test, then context line through the back half
  sbpo_pkg::ctx_t ctx_r [CD];
  logic           v_r   [CD];
  sbpo_pkg::ctx_t ctx_nxt;
  logic [NW-1:0]  dist_nxt;

  always_comb begin
    dist_nxt     = NW'(d_sq_r[0]) + NW'(d_sq_r[1]) + NW'(d_sq_r[2]);
    ctx_nxt.hit  = !d_far_r && (dist_nxt < NW'(d_rr_r));
    ctx_nxt.neg  = d_neg_r;
    ctx_nxt.push = d_push_r;
    for (int i = 0; i < 3; i++) begin
      ctx_nxt.cl[i] = d_cl_r[i];
      ctx_nxt.sc[i] = d_s_r[i];
      ctx_nxt.e[i]  = d_e_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CD; k++) begin
        v_r[k] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= vd_r;
      for (int k = 1; k < CD; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // normalize: shift count so the largest magnitude has bit EW-1 set
  logic [EW-1:0] m0_r;
  logic [4:0]    lz_r;
  logic [EW-1:0] mm;
  logic [4:0]    lz_nxt;

  always_comb begin
    mm     = m0_r;
    lz_nxt = '0;
    if (mm[EW-1 -: 16] == '0) begin
      mm = mm << 16;
      lz_nxt = lz_nxt + 5'd16;
    end
    if (mm[EW-1 -: 8] == '0) begin
      mm = mm << 8;
      lz_nxt = lz_nxt + 5'd8;
    end
    if (mm[EW-1 -: 4] == '0) begin
      mm = mm << 4;
      lz_nxt = lz_nxt + 5'd4;
    end
    if (mm[EW-1 -: 2] == '0) begin
      mm = mm << 2;
      lz_nxt = lz_nxt + 5'd2;
    end
    if (mm[EW-1] == 1'b0) begin
      lz_nxt = lz_nxt + 5'd1;
    end
  end

  sbpo_pkg::ctx_t ctx_sh;

  always_comb begin
    ctx_sh = ctx_r[1];
    for (int i = 0; i < 3; i++) begin
      ctx_sh.e[i] = ctx_r[1].e[i] << lz_r;
    end
  end

  logic [SW-1:0] esq_r [3];
  logic [NW-1:0] ssum_r;
  logic [LW-1:0] len;
  logic [LW-1:0] len_r;
  logic [NW-1:0] prod_r [3];
  logic [NW-1:0] p_r    [3];
  logic [LW-1:0] den_r;
  logic [QW-1:0] q      [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx_r[0] <= ctx_nxt;
      m0_r     <= d_m_r;
      lz_r     <= lz_nxt;
      for (int k = 1; k < CD; k++) begin
        if (k == 2) begin
          ctx_r[k] <= ctx_sh;
        end else begin
          ctx_r[k] <= ctx_r[k-1];
        end
      end
      for (int i = 0; i < 3; i++) begin
        esq_r[i]  <= SW'(ctx_r[2].e[i]) * SW'(ctx_r[2].e[i]);
        prod_r[i] <= NW'(ctx_r[IS].e[i]) * NW'(ctx_r[IS].push);
        p_r[i]    <= prod_r[i] + NW'(len_r >> 1);
      end
      ssum_r <= NW'(esq_r[0]) + NW'(esq_r[1]) + NW'(esq_r[2]);
      len_r  <= len;
      den_r  <= len_r;
    end
  end

  sbpo_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .x_in (ssum_r),
    .root (len)
  );

  for (genvar g = 0; g < 3; g++) begin : g_div
    sbpo_div u_div (
      .clk    (clk),
      .en     (adv),
      .num_in (p_r[g]),
      .den_in (den_r),
      .quo    (q[g])
    );
  end

  // offset, add, saturate
  sbpo_pkg::out_t out_r;
  sbpo_pkg::out_t out_nxt;
  logic signed [AW+1:0] off  [3];
  logic signed [AW+1:0] sum  [3];
  logic signed [CW-1:0] rsat [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      off[i] = $signed({2'b00, q[i]});
      if (ctx_r[CD-1].neg[i]) begin
        off[i] = -off[i];
      end
      sum[i] = (AW+2)'($signed(ctx_r[CD-1].cl[i])) + off[i];
      if (!sum[i][AW+1] && (sum[i][AW:CW-1] != '0)) begin
        rsat[i] = {1'b0, {(CW-1){1'b1}}};
      end else if (sum[i][AW+1] && (sum[i][AW:CW-1] != '1)) begin
        rsat[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        rsat[i] = sum[i][CW-1:0];
      end
      if (!ctx_r[CD-1].hit) begin
        rsat[i] = $signed(ctx_r[CD-1].sc[i]);
      end
    end
    out_nxt.hit          = ctx_r[CD-1].hit;
    out_nxt.new_center_x = rsat[0];
    out_nxt.new_center_y = rsat[1];
    out_nxt.new_center_z = rsat[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v_r[CD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

`ifndef SYNTHESIS
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid set after reset");
  a_len_norm: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[IS] && ctx_r[IS].hit |-> len[LW-1:LW-2] != 2'b00)
    else $error("length below normalized range");
  a_q_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[CD-1] && ctx_r[CD-1].hit |-> !q[0][QW-1] && !q[1][QW-1] && !q[2][QW-1])
    else $error("offset quotient out of range");
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v_r[CD-1]) && $stable(v_r[0]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire
